[hw/rtl/pairwise_monopole_accumulator_unit_defines.svh]
// assertion macros used by the checker module
`ifndef PAIRWISE_MONOPOLE_ACCUMULATOR_UNIT_DEFINES_SVH
`define PAIRWISE_MONOPOLE_ACCUMULATOR_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PMA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pma_pkg.sv]
package pma_pkg;

  // cell store geometry (cell count is a power of two)
  localparam int NUM_CELLS    = 512;
  localparam int CELL_W       = $clog2(NUM_CELLS);
  localparam int CELL_FIELD_W = 9;

  // data widths
  localparam int VAL_W = 32;
  localparam int ACC_W = 48;
  localparam int LANES = 4;

  // lane order inside an accumulator word
  localparam int LANE_POT = 0;
  localparam int LANE_FX  = 1;
  localparam int LANE_FY  = 2;
  localparam int LANE_FZ  = 3;

  // command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_PAIR = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // 1.0 in unsigned q16.16
  localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef logic [CELL_W-1:0]             cell_idx_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [LANES-1:0][ACC_W-1:0]   acc_word_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [63:0] ACC_MAX_MAG = 64'(ACC_MAX);

  // cell index reduced into the store range
  function automatic cell_idx_t cell_index(logic [CELL_FIELD_W-1:0] v);
    return CELL_W'(32'(v) % NUM_CELLS);
  endfunction

  // 48-bit signed add that clamps on overflow
  function automatic acc_t sat_add(acc_t a, acc_t b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return acc_t'(s[ACC_W-1:0]);
  endfunction

endpackage

[hw/rtl/pma_lane.sv]
module pma_lane import pma_pkg::*; (
  input  logic                    clk,
  input  logic signed [VAL_W-1:0] mass_i,
  input  logic signed [VAL_W-1:0] geo_i,
  input  logic                    negate_i,
  input  logic [VAL_W-1:0]        scale_i,
  output acc_t                    term_o
);

  localparam logic [64:0] RND_HALF = 65'h0_8000_0000;

  logic signed [63:0] prod_r;
  logic               neg1_r;
  logic [62:0]        mag_r;
  logic               neg2_r;
  logic [62:0]        hs_r;
  logic [63:0]        ls_r;
  logic               neg3_r;
  acc_t               term_r;

  logic [32:0]        rnd;
  logic [63:0]        q;
  acc_t               term_nxt;

  // stage 1: exact q32.32 product
  always_ff @(posedge clk) begin
    prod_r <= 64'(mass_i) * 64'(geo_i);
    neg1_r <= negate_i;
  end

  // stage 2: magnitude and final sign
  always_ff @(posedge clk) begin
    mag_r  <= prod_r[63] ? 63'(64'd0 - prod_r) : 63'(prod_r);
    neg2_r <= prod_r[63] ^ neg1_r;
  end

  // stage 3: scale high and low halves separately
  always_ff @(posedge clk) begin
    hs_r   <= 63'(mag_r[62:32]) * 63'(scale_i);
    ls_r   <= 64'(mag_r[31:0]) * 64'(scale_i);
    neg3_r <= neg2_r;
  end

  // stage 4: round half away from zero, apply sign, clamp to 48 bits
  always_comb begin
    rnd = 33'((65'(ls_r) + RND_HALF) >> 32);
    q   = 64'(hs_r) + 64'(rnd);
    if (neg3_r) begin
      if (q > ACC_MAX_MAG + 64'd1) begin
        term_nxt = ACC_MIN;
      end else begin
        term_nxt = acc_t'(64'd0 - q);
      end
    end else begin
      if (q > ACC_MAX_MAG) begin
        term_nxt = ACC_MAX;
      end else begin
        term_nxt = acc_t'(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  assign term_o = term_r;

endmodule

[hw/rtl/pairwise_monopole_accumulator_unit.sv]
// channel   | qualifier          | payload
// command   | start && !busy     | in_cmd, in_cell_a, in_cell_b, in_mass_value, in_geo_*
// result    | out_valid (1 cyc)  | out_cell, out_sum_pot, out_sum_fx, out_sum_fy, out_sum_fz
// config    | psel&penable&pwrite| paddr, pwdata (0: inv_dx, 4: inv_dx_sq), prdata
//
// a load writes in the transfer cycle; a read-and-clear goes through S_RDCLR, which
// registers the result strobe; a pair interaction does two mass reads, a four-stage
// lane pipeline, then a read and a write of each cell on the accumulator memory.
// after reset a clearing pass zeroes all 512 accumulator cells with busy high.
// results cannot be held off; a new command is taken only once busy drops.
module pairwise_monopole_accumulator_unit import pma_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_cmd,
  input  logic [CELL_FIELD_W-1:0]        in_cell_a,
  input  logic [CELL_FIELD_W-1:0]        in_cell_b,
  input  logic signed [VAL_W-1:0]        in_mass_value,
  input  logic signed [VAL_W-1:0]        in_geo_pot,
  input  logic signed [VAL_W-1:0]        in_geo_x,
  input  logic signed [VAL_W-1:0]        in_geo_y,
  input  logic signed [VAL_W-1:0]        in_geo_z,
  output logic                           out_valid,
  output logic [CELL_FIELD_W-1:0]        out_cell,
  output logic signed [ACC_W-1:0]        out_sum_pot,
  output logic signed [ACC_W-1:0]        out_sum_fx,
  output logic signed [ACC_W-1:0]        out_sum_fy,
  output logic signed [ACC_W-1:0]        out_sum_fz,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_MASS  = 3'd2;
  localparam logic [2:0] S_INJA  = 3'd3;
  localparam logic [2:0] S_GAP   = 3'd4;
  localparam logic [2:0] S_INJB  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_RDCLR = 3'd7;

  logic [2:0]             state_r, state_nxt;
  cell_idx_t              clr_cnt_r;
  cell_idx_t              a_r, b_r;
  logic [LANES-1:0][VAL_W-1:0] geo_r;
  logic [VAL_W-1:0]       inv_dx_r, inv_dx_sq_r;

  logic [VAL_W-1:0]       mass_mem [NUM_CELLS];
  logic signed [VAL_W-1:0] mass_rd_r, ma_r;
  acc_word_t              acc_mem [NUM_CELLS];
  acc_word_t              acc_rd_r;

  logic [4:1]             vld_r;
  logic [4:1]             side_r;

  logic                   out_valid_r;
  logic [CELL_FIELD_W-1:0] out_cell_r;
  acc_word_t              out_word_r;

  logic                   accept;
  cell_idx_t              in_a_idx;
  logic                   cfg_we;
  logic                   inj, inj_side_b;
  logic signed [VAL_W-1:0] inj_mass;
  acc_word_t              term;

  logic                   mass_we, mass_re;
  cell_idx_t              mass_ra;
  logic                   acc_we, acc_re;
  cell_idx_t              acc_wa, acc_ra;
  acc_word_t              acc_wd;

  assign accept   = start && !busy;
  assign in_a_idx = cell_index(in_cell_a);
  assign busy     = (state_r != S_IDLE);

  // configuration registers
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? inv_dx_sq_r : inv_dx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_dx_r    <= ONE_Q16;
      inv_dx_sq_r <= ONE_Q16;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        inv_dx_sq_r <= pwdata;
      end else begin
        inv_dx_r <= pwdata;
      end
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r   <= in_a_idx;
      b_r   <= cell_index(in_cell_b);
      geo_r <= {in_geo_z, in_geo_y, in_geo_x, in_geo_pot};
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_PAIR) begin
          state_nxt = S_MASS;
        end else if (accept && in_cmd == CMD_READ) begin
          state_nxt = S_RDCLR;
        end
      end
      S_CLEAR: begin
        if (clr_cnt_r == CELL_W'(NUM_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_MASS:  state_nxt = S_INJA;
      S_INJA:  state_nxt = S_GAP;
      S_GAP:   state_nxt = S_INJB;
      S_INJB:  state_nxt = S_DRAIN;
      S_DRAIN: begin
        if (vld_r[4] && side_r[4]) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDCLR: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + CELL_W'(1);
      end
    end
  end

  // mass memory: load writes, a pair reads cell a then cell b
  assign mass_we = accept && in_cmd == CMD_LOAD;
  assign mass_re = (accept && in_cmd == CMD_PAIR) || state_r == S_MASS;
  assign mass_ra = (state_r == S_MASS) ? b_r : in_a_idx;

  always_ff @(posedge clk) begin
    if (mass_we) begin
      mass_mem[in_a_idx] <= in_mass_value;
    end
    if (mass_re) begin
      mass_rd_r <= mass_mem[mass_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MASS) begin
      ma_r <= mass_rd_r;
    end
  end

  // cell a takes mass of b in S_INJA, cell b takes mass of a in S_INJB after S_GAP
  assign inj        = (state_r == S_INJA) || (state_r == S_INJB);
  assign inj_side_b = (state_r == S_INJB);
  assign inj_mass   = inj_side_b ? ma_r : mass_rd_r;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    pma_lane u_lane (
      .clk      (clk),
      .mass_i   (inj_mass),
      .geo_i    (signed'(geo_r[l])),
      .negate_i ((l != LANE_POT) && inj_side_b),
      .scale_i  ((l == LANE_POT) ? inv_dx_r : inv_dx_sq_r),
      .term_o   (term[l])
    );
  end

  // lane pipeline tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      side_r <= '0;
    end else begin
      vld_r  <= {vld_r[3:1], inj};
      side_r <= {side_r[3:1], inj_side_b};
    end
  end

  // accumulator port: read as the term leaves stage 3, write back next cycle
  always_comb begin
    acc_we = 1'b0;
    acc_wa = a_r;
    acc_wd = '0;
    acc_re = 1'b0;
    acc_ra = a_r;
    if (state_r == S_CLEAR) begin
      acc_we = 1'b1;
      acc_wa = clr_cnt_r;
    end
    if (state_r == S_RDCLR) begin
      acc_we = 1'b1;
    end
    if (accept && in_cmd == CMD_READ) begin
      acc_re = 1'b1;
      acc_ra = in_a_idx;
    end
    if (vld_r[3]) begin
      acc_re = 1'b1;
      acc_ra = side_r[3] ? b_r : a_r;
    end
    if (vld_r[4]) begin
      acc_we = 1'b1;
      acc_wa = side_r[4] ? b_r : a_r;
      for (int l = 0; l < LANES; l++) begin
        acc_wd[l] = sat_add(acc_t'(acc_rd_r[l]), acc_t'(term[l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    if (acc_re) begin
      acc_rd_r <= acc_mem[acc_ra];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_RDCLR);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RDCLR) begin
      out_cell_r <= CELL_FIELD_W'(a_r);
      out_word_r <= acc_rd_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_cell    = out_cell_r;
  assign out_sum_pot = acc_t'(out_word_r[LANE_POT]);
  assign out_sum_fx  = acc_t'(out_word_r[LANE_FX]);
  assign out_sum_fy  = acc_t'(out_word_r[LANE_FY]);
  assign out_sum_fz  = acc_t'(out_word_r[LANE_FZ]);

endmodule

[hw/rtl/pma_checker.sv]
`include "pairwise_monopole_accumulator_unit_defines.svh"

module pma_checker import pma_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [1:0]              in_cmd,
  input logic [CELL_FIELD_W-1:0] in_cell_a,
  input logic                    out_valid,
  input logic [CELL_FIELD_W-1:0] out_cell
);

  // a read transfer is followed by its result strobe, via the read-and-clear state
  `PMA_ASSERT_SAME(a_read_strobe, start && !busy && in_cmd == CMD_READ, ##2 out_valid, "read gave no result")

  // the strobe reports the cell named by that read
  `PMA_ASSERT_SAME(a_read_cell, out_valid, out_cell == CELL_FIELD_W'(cell_index($past(in_cell_a, 2))), "result cell mismatch")

  // results are single-cycle pulses
  `PMA_ASSERT_NEXT(a_strobe_pulse, out_valid, !out_valid, "result strobe held")

  // a load completes in its own cycle
  `PMA_ASSERT_NEXT(a_load_fast, start && !busy && in_cmd == CMD_LOAD, !busy, "load kept busy")

  // a pair interaction occupies the unit
  `PMA_ASSERT_NEXT(a_pair_busy, start && !busy && in_cmd == CMD_PAIR, busy && !out_valid, "pair not busy")

endmodule

bind pairwise_monopole_accumulator_unit pma_checker u_pma_checker (.*);
